### hdl/sti_pkg.sv
// Shared constants, codes and controller/datapath interface types for the search unit.
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int LEN_W  = 9;
    localparam int EIDX_W = 8;
    localparam int POS_W  = 8;

    // Divider: the quotient never exceeds hi - lo, so it has IDX_W bits
    localparam int QW     = IDX_W;
    localparam int PROD_W = DATA_W + IDX_W;
    localparam int CNT_W  = (QW > 1) ? $clog2(QW) : 1;

    // Item mode codes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CAP_HI,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_RD_MID,
        S_CMP_MID,
        S_FINISH
    } state_t;

    // Table read address source
    typedef enum logic [1:0] {
        ASEL_LO,
        ASEL_HI,
        ASEL_MID
    } asel_t;

    // Result selection
    typedef enum logic [1:0] {
        RES_MISS,
        RES_LO,
        RES_MID
    } res_t;

    typedef struct packed {
        logic  wr_entry;
        logic  ld_query;
        logic  ld_vlo;
        logic  ld_vhi;
        logic  ld_diff;
        logic  ld_mul;
        logic  div_step;
        logic  rd_mid;
        logic  step_lo;
        logic  step_hi;
        logic  set_res;
        res_t  res_sel;
        logic  finish;
        asel_t asel;
    } cmd_t;

    typedef struct packed {
        logic key_out;
        logic ends_eq;
        logic key_eq_lo;
        logic div_last;
        logic mid_lt;
        logic mid_gt;
        logic mid_at_lo;
        logic mid_at_hi;
        logic slot_free;
    } stat_t;

endpackage
`default_nettype wire

### hdl/sti_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                         wdata,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hdl/sti_ctrl.sv
// Search sequencer: steps one query through reads, interpolation divide and narrowing.
`timescale 1ns / 1ps
`default_nettype none
module sti_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           mode,
    output logic                item_stall,
    input  wire sti_pkg::stat_t stat,
    output sti_pkg::cmd_t       cmd
);
    import sti_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RES_MISS;
        cmd.asel    = ASEL_LO;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        cmd.wr_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.ld_query = 1'b1;
                        state_next   = S_RD_LO;
                    end
                end
            end
            S_RD_LO:
            begin
                cmd.asel   = ASEL_LO;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.asel   = ASEL_HI;
                cmd.ld_vlo = 1'b1;
                state_next = S_CAP_HI;
            end
            S_CAP_HI:
            begin
                cmd.asel   = ASEL_HI;
                cmd.ld_vhi = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.key_out)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_MISS;
                    state_next  = S_FINISH;
                end
                else if (stat.ends_eq)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = stat.key_eq_lo ? RES_LO : RES_MISS;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.ld_diff = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.ld_mul = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RD_MID;
                end
            end
            S_RD_MID:
            begin
                cmd.asel   = ASEL_MID;
                cmd.rd_mid = 1'b1;
                state_next = S_CMP_MID;
            end
            S_CMP_MID:
            begin
                cmd.asel = ASEL_MID;
                if (stat.mid_lt)
                begin
                    if (stat.mid_at_hi)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_MISS;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        cmd.step_lo = 1'b1;
                        state_next  = S_RD_LO;
                    end
                end
                else if (stat.mid_gt)
                begin
                    if (stat.mid_at_lo)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_MISS;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        cmd.step_hi = 1'b1;
                        state_next  = S_RD_LO;
                    end
                end
                else
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_MID;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Wait for the output register to free up
                if (stat.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/sti_dp.sv
// Search datapath: table RAM, bounds, interpolation multiply, serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module sti_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sti_pkg::cmd_t                       cmd,
    output sti_pkg::stat_t                           stat,
    input  wire logic                                cfg_valid,
    input  wire logic        [sti_pkg::LEN_W-1:0]    table_length,
    input  wire logic        [sti_pkg::EIDX_W-1:0]   entry_index,
    input  wire logic signed [sti_pkg::DATA_W-1:0]   entry_value,
    input  wire logic signed [sti_pkg::DATA_W-1:0]   search_key,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     found,
    output logic             [sti_pkg::POS_W-1:0]    position
);
    import sti_pkg::*;

    // Configuration and search registers
    logic        [LEN_W-1:0]  tl_reg;
    logic        [IDX_W-1:0]  lo_reg;
    logic        [IDX_W-1:0]  hi_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] vlo_reg;
    logic signed [DATA_W-1:0] vhi_reg;
    logic        [DATA_W-1:0] num_reg;
    logic        [DATA_W-1:0] den_reg;
    logic        [IDX_W-1:0]  span_reg;
    logic        [PROD_W-1:0] rem_reg;
    logic        [PROD_W-1:0] dsh_reg;
    logic        [QW-1:0]     quo_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     res_found_reg;
    logic        [IDX_W-1:0]  res_idx_reg;
    logic                     result_valid_reg;
    logic                     found_reg;
    logic        [POS_W-1:0]  position_reg;

    logic        [IDX_W-1:0]  hi_init;
    logic        [IDX_W-1:0]  mid_w;
    logic signed [DATA_W:0]   num_full;
    logic signed [DATA_W:0]   den_full;
    logic        [PROD_W-1:0] prod_w;
    logic                     div_ge;
    logic        [IDX_W-1:0]  ram_addr;
    logic                     ram_we;
    logic        [DATA_W-1:0] ram_rdata;
    logic signed [DATA_W-1:0] vm;

    // Table storage
    sti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (entry_value),
        .rdata (ram_rdata)
    );

    assign ram_we = cmd.wr_entry && (int'(entry_index) < TABLE_DEPTH);

    always_comb
    begin
        if (cmd.wr_entry)
        begin
            ram_addr = IDX_W'(entry_index);
        end
        else
        begin
            case (cmd.asel)
                ASEL_LO:  ram_addr = lo_reg;
                ASEL_HI:  ram_addr = hi_reg;
                ASEL_MID: ram_addr = mid_w;
                default:  ram_addr = lo_reg;
            endcase
        end
    end

    assign vm = $signed(ram_rdata);

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            tl_reg <= table_length;
        end
    end

    // Upper bound from length: zero acts as one, large values saturate
    always_comb
    begin
        if (tl_reg == '0)
        begin
            hi_init = '0;
        end
        else if (int'(tl_reg) > TABLE_DEPTH)
        begin
            hi_init = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            hi_init = IDX_W'(tl_reg - LEN_W'(1));
        end
    end

    // Interpolation operands
    assign mid_w    = lo_reg + quo_reg;
    assign num_full = $signed({key_reg[DATA_W-1], key_reg}) - $signed({vlo_reg[DATA_W-1], vlo_reg});
    assign den_full = $signed({vhi_reg[DATA_W-1], vhi_reg}) - $signed({vlo_reg[DATA_W-1], vlo_reg});
    assign prod_w   = {{IDX_W{1'b0}}, num_reg} * {{DATA_W{1'b0}}, span_reg};
    assign div_ge   = (rem_reg >= dsh_reg);

    // Bounds, operands and restoring divider
    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            key_reg <= search_key;
            lo_reg  <= '0;
            hi_reg  <= hi_init;
        end
        if (cmd.ld_vlo)
        begin
            vlo_reg <= vm;
        end
        if (cmd.ld_vhi)
        begin
            vhi_reg <= vm;
        end
        if (cmd.ld_diff)
        begin
            num_reg  <= num_full[DATA_W-1:0];
            den_reg  <= den_full[DATA_W-1:0];
            span_reg <= hi_reg - lo_reg;
        end
        if (cmd.ld_mul)
        begin
            rem_reg <= prod_w;
            dsh_reg <= {{IDX_W{1'b0}}, den_reg} << (QW - 1);
            quo_reg <= '0;
            cnt_reg <= CNT_W'(QW - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= QW'({quo_reg, div_ge});
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.step_lo)
        begin
            lo_reg <= mid_w + IDX_W'(1);
        end
        if (cmd.step_hi)
        begin
            hi_reg <= mid_w - IDX_W'(1);
        end
        if (cmd.set_res)
        begin
            case (cmd.res_sel)
                RES_LO:
                begin
                    res_found_reg <= 1'b1;
                    res_idx_reg   <= lo_reg;
                end
                RES_MID:
                begin
                    res_found_reg <= 1'b1;
                    res_idx_reg   <= mid_w;
                end
                default:
                begin
                    res_found_reg <= 1'b0;
                    res_idx_reg   <= '0;
                end
            endcase
        end
        if (cmd.finish)
        begin
            found_reg    <= res_found_reg;
            position_reg <= POS_W'(res_idx_reg);
        end
    end

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign position     = position_reg;

    // Status to the sequencer
    always_comb
    begin
        stat.key_out   = (key_reg < vlo_reg) || (key_reg > vhi_reg);
        stat.ends_eq   = (vlo_reg == vhi_reg);
        stat.key_eq_lo = (key_reg == vlo_reg);
        stat.div_last  = (cnt_reg == '0);
        stat.mid_lt    = (vm < key_reg);
        stat.mid_gt    = (vm > key_reg);
        stat.mid_at_lo = (mid_w == lo_reg);
        stat.mid_at_hi = (mid_w == hi_reg);
        stat.slot_free = !result_valid_reg || !result_stall;
    end

    // Key lies inside the bounds, so the numerator never exceeds the span of values
    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_mul |-> (num_reg <= den_reg))
        else $error("interpolation numerator exceeds denominator");

    // Interpolated probe stays within the bounds
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_mid |-> ((mid_w <= hi_reg) && (mid_w >= lo_reg)))
        else $error("probe index outside bounds");

    // A new result beat only comes from a finished query
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(cmd.finish))
        else $error("result beat without finished query");

    // Finishing never overwrites a result still held back
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!result_valid_reg || !result_stall))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### hdl/sorted_table_interpolation_search_unit.sv
// Top level of the sorted-table interpolation search unit.
//
// Holds a table of 256 signed 32-bit entries kept in ascending order by the
// user. A write beat (mode 0) stores entry_value at entry_index and returns
// nothing. A search beat (mode 1) looks up search_key among the first
// table_length entries (0 acts as 1, values above 256 saturate) and returns
// one beat with found and position (0 when not found). Entries must be
// written before a search reads them. A search can be settled by the first
// bounds check (key out of range or equal end values). Each interpolation
// probe takes three table reads through the single RAM port, one multiply
// and an 8-step restoring divide. A search can also end on a probe compare
// (hit, or bounds crossing). The unit works on one item at a time; a
// finished result waits in the output register while the next item is
// accepted. table_length is taken when a search beat is accepted; the user
// writes it over the cfg port while no search is running, which the block
// itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_interpolation_search_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                mode,
    input  wire logic        [sti_pkg::EIDX_W-1:0]   entry_index,
    input  wire logic signed [sti_pkg::DATA_W-1:0]   entry_value,
    input  wire logic signed [sti_pkg::DATA_W-1:0]   search_key,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     found,
    output logic             [sti_pkg::POS_W-1:0]    position,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [sti_pkg::LEN_W-1:0]    table_length
);
    import sti_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Length register always takes a write; searches sample it at accept
    assign cfg_ready = 1'b1;

    // Sequencer
    sti_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .mode       (mode),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath
    sti_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .table_length (table_length),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .search_key   (search_key),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .position     (position)
    );

endmodule
`default_nettype wire
